// ===== hdl/gsfs_pkg.sv =====
// Package for the GGA sentence field splitter.
// Holds the character constants, the header table and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package gsfs_pkg;

    // Default limit on stored characters per field.
    localparam int DEF_MAX_FIELD_CHARS = 16;

    // Header group length and field limits.
    localparam logic [2:0] HDR_LAST   = 3'd5;
    localparam logic [3:0] FIELD_LAST = 4'd12;
    localparam logic [3:0] FIELD_SAT  = 4'd15;

    // Characters with a special meaning.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    // One result word as it leaves the parser.
    typedef struct packed {
        logic       emit;
        logic [3:0] field_number;
        logic [3:0] char_position;
        logic [7:0] char_value;
        logic       sentence_end;
    } gsfs_result_t;

    // Expected header character at a given position of the group.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24; // '$'
            3'd1:    c = 8'h47; // 'G'
            3'd2:    c = 8'h50; // 'P'
            3'd3:    c = 8'h47; // 'G'
            3'd4:    c = 8'h47; // 'G'
            3'd5:    c = 8'h41; // 'A'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/gsfs_parser.sv =====
// Parser state and per-word decode for the GGA sentence field splitter.
// Depends on gsfs_pkg. The state advances on every word passed with step_en.
`timescale 1ns / 1ps

module gsfs_parser import gsfs_pkg::*; #(
    parameter int MAX_FIELD_CHARS = DEF_MAX_FIELD_CHARS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   rx_byte,
    output gsfs_result_t result
);

    localparam int POS_W = $clog2(MAX_FIELD_CHARS + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FIELD_CHARS);

    logic [2:0]       hdr_pos_reg,  hdr_pos_next;
    logic             hdr_mm_reg,   hdr_mm_next;
    logic             in_sent_reg,  in_sent_next;
    logic [3:0]       field_reg,    field_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             mm_acc;

    // Next state and result for the current word.
    always_comb begin
        hdr_pos_next = hdr_pos_reg;
        hdr_mm_next  = hdr_mm_reg;
        in_sent_next = in_sent_reg;
        field_next   = field_reg;
        pos_next     = pos_reg;
        mm_acc       = hdr_mm_reg | (rx_byte != hdr_char(hdr_pos_reg));
        result       = '0;

        if (!in_sent_reg) begin
            // Hunting: a group opens on a dollar and always runs six words.
            if (hdr_pos_reg == 3'd0) begin
                if (rx_byte == CHAR_DOLLAR) begin
                    hdr_pos_next = 3'd1;
                    hdr_mm_next  = 1'b0;
                end
            end else if (hdr_pos_reg == HDR_LAST) begin
                if (!mm_acc) begin
                    in_sent_next = 1'b1;
                    field_next   = '0;
                    pos_next     = '0;
                end
                hdr_pos_next = 3'd0;
                hdr_mm_next  = 1'b0;
            end else begin
                hdr_pos_next = hdr_pos_reg + 3'd1;
                hdr_mm_next  = mm_acc;
            end
        end else if (rx_byte == CHAR_STAR) begin
            // End of sentence: emit the marker and go back to hunting.
            in_sent_next        = 1'b0;
            hdr_pos_next        = 3'd0;
            hdr_mm_next         = 1'b0;
            result.emit         = 1'b1;
            result.sentence_end = 1'b1;
        end else if (rx_byte == CHAR_COMMA) begin
            // Field separator: the field count saturates instead of wrapping.
            if (field_reg != FIELD_SAT) begin
                field_next = field_reg + 4'd1;
            end
            pos_next = '0;
        end else if (pos_reg < POS_MAX) begin
            // Field data: only fields one through twelve are passed on.
            pos_next = pos_reg + POS_W'(1);
            if (field_reg inside {[4'd1:FIELD_LAST]}) begin
                result.emit          = 1'b1;
                result.field_number  = field_reg;
                result.char_position = pos_reg[3:0];
                result.char_value    = rx_byte;
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg <= '0;
            hdr_mm_reg  <= 1'b0;
            in_sent_reg <= 1'b0;
            field_reg   <= '0;
            pos_reg     <= '0;
        end else if (step_en) begin
            hdr_pos_reg <= hdr_pos_next;
            hdr_mm_reg  <= hdr_mm_next;
            in_sent_reg <= in_sent_next;
            field_reg   <= field_next;
            pos_reg     <= pos_next;
        end
    end

    // Hunting words never produce a result.
    a_no_emit_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !in_sent_reg |-> !result.emit)
        else $error("result produced while hunting");

    // The end marker always drops the parser back into hunting.
    a_end_returns_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.emit && result.sentence_end |=> !in_sent_reg && hdr_pos_reg == 3'd0)
        else $error("end marker did not restart hunting");

    // The header group position stays within the six-word group.
    a_hdr_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_pos_reg <= HDR_LAST)
        else $error("header position out of range");

    // The character position saturates at the field length limit.
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("character position beyond limit");

    // A sentence is only entered by completing a header group while hunting.
    a_enter_sentence: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !in_sent_reg && hdr_pos_reg != HDR_LAST |=> !in_sent_reg)
        else $error("sentence entered before header group completed");

endmodule

// ===== hdl/gga_sentence_field_splitter_top.sv =====
// Path: an accepted input word passes the input register and then the result register;
// words that give no result simply leave the pipeline.
// Throughput: one input word per cycle while the result register is free or draining.
// A result waiting on m_ready holds the input register, but an empty input register still takes a word.
// Reset: aresetn is synchronous and active low; it empties both registers and restarts hunting.
`timescale 1ns / 1ps

module gga_sentence_field_splitter_top import gsfs_pkg::*; #(
    parameter int MAX_FIELD_CHARS = DEF_MAX_FIELD_CHARS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_field_number,
    output logic [3:0] m_char_position,
    output logic [7:0] m_char_value,
    output logic       m_sentence_end
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    gsfs_result_t out_reg;
    gsfs_result_t result;
    logic         advance;

    // The input word moves on whenever the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    gsfs_parser #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_field_number  = out_reg.field_number;
    assign m_char_position = out_reg.char_position;
    assign m_char_value    = out_reg.char_value;
    assign m_sentence_end  = out_reg.sentence_end;

endmodule

// ===== sim/tb_gga_sentence_field_splitter_top.sv =====
// Self-checking testbench for the GGA sentence field splitter.
// Depends on hdl/gsfs_pkg.sv, hdl/gsfs_parser.sv and hdl/gga_sentence_field_splitter_top.sv.
// A built-in model of the parser predicts every character word and end marker.
`timescale 1ns / 1ps

module tb_gga_sentence_field_splitter_top;
    import gsfs_pkg::*;

    localparam int FIELD_CHARS = DEF_MAX_FIELD_CHARS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES = 300;

    // Header characters of a GGA sentence, by position in the group.
    localparam logic [7:0] GGA_TAG [0:5] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};

    typedef struct {
        logic [3:0] field_number;
        logic [3:0] char_position;
        logic [7:0] char_value;
        logic       sentence_end;
    } field_char_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [3:0] m_field_number;
    logic [3:0] m_char_position;
    logic [7:0] m_char_value;
    logic       m_sentence_end;

    // Parser model state.
    logic [2:0] hdr_pos    = 3'd0;
    logic       hdr_bad    = 1'b0;
    logic       splitting  = 1'b0;
    logic [3:0] field_cnt  = 4'd0;
    int         char_pos   = 0;

    field_char_t pending_chars[$];
    int          err_count     = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          hold_left     = 0;
    int          sentence_words = 0;

    gga_sentence_field_splitter_top #(
        .MAX_FIELD_CHARS(FIELD_CHARS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_number (m_field_number),
        .m_char_position(m_char_position),
        .m_char_value   (m_char_value),
        .m_sentence_end (m_sentence_end)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit in case the block hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Prints one mismatch line, up to a limit, and counts every one.
    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Advances the parser model by one accepted word and queues any result it gives.
    task automatic gga_track_byte(input logic [7:0] b);
        field_char_t r;
        if (!splitting) begin
            if (hdr_pos == 3'd0) begin
                if (b == CHAR_DOLLAR) begin
                    hdr_pos = 3'd1;
                    hdr_bad = 1'b0;
                end
            end else begin
                if (b != GGA_TAG[hdr_pos])
                    hdr_bad = 1'b1;
                if (hdr_pos == HDR_LAST) begin
                    if (!hdr_bad) begin
                        splitting = 1'b1;
                        field_cnt = 4'd0;
                        char_pos  = 0;
                    end
                    hdr_pos = 3'd0;
                    hdr_bad = 1'b0;
                end else begin
                    hdr_pos = hdr_pos + 3'd1;
                end
            end
        end else if (b == CHAR_STAR) begin
            splitting = 1'b0;
            hdr_pos   = 3'd0;
            hdr_bad   = 1'b0;
            r = '{field_number: 4'd0, char_position: 4'd0, char_value: 8'd0, sentence_end: 1'b1};
            pending_chars.push_back(r);
        end else if (b == CHAR_COMMA) begin
            if (field_cnt != FIELD_SAT)
                field_cnt = field_cnt + 4'd1;
            char_pos = 0;
        end else if (char_pos < FIELD_CHARS) begin
            // Field zero and fields past the last one still advance the position.
            if (field_cnt >= 4'd1 && field_cnt <= FIELD_LAST) begin
                r.field_number  = field_cnt;
                r.char_position = char_pos[3:0];
                r.char_value    = b;
                r.sentence_end  = 1'b0;
                pending_chars.push_back(r);
            end
            char_pos++;
        end
    endtask

    // Offers one word in bursts with random gaps and waits until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_valid   <= 1'b0;
                s_rx_byte <= 8'($urandom);
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        // Inputs only change at rising edges, so ready at the falling edge holds to the next one.
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        gga_track_byte(b);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Receiver: switches between stall patterns, or holds off entirely on request.
    initial begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // Result checker: a word moves at the next rising edge when valid and ready are both high.
    initial begin : result_check
        field_char_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected word field=%0d pos=%0d char=%02h end=%0b",
                        m_field_number, m_char_position, m_char_value, m_sentence_end));
                end else begin
                    want = pending_chars.pop_front();
                    if (m_field_number !== want.field_number)
                        report_mismatch($sformatf("field_number %0d, expected %0d",
                            m_field_number, want.field_number));
                    if (m_char_position !== want.char_position)
                        report_mismatch($sformatf("char_position %0d, expected %0d",
                            m_char_position, want.char_position));
                    if (m_char_value !== want.char_value)
                        report_mismatch($sformatf("char_value %02h, expected %02h",
                            m_char_value, want.char_value));
                    if (m_sentence_end !== want.sentence_end)
                        report_mismatch($sformatf("sentence_end %0b, expected %0b",
                            m_sentence_end, want.sentence_end));
                end
            end
        end
    end

    // Header hunting: stray bytes, a group that starts on a doubled dollar, a late mismatch.
    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("GPGGA,1*");
        send_text("$$GPGGA,9*");
        send_text("$GPGGX,5*");
    endtask

    // Field zero is dropped; extreme characters and a dollar pass as data.
    task automatic test_field_extremes();
        send_text("$GPGGAq,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$,,7*");
    endtask

    // Over-long field, then fields past twelve with the counter driven into saturation.
    task automatic test_field_limits();
        send_text("$GPGGA,");
        for (int i = 0; i < FIELD_CHARS + 2; i++)
            send_byte(8'(8'h30 + i));
        for (int i = 0; i < 12; i++)
            send_byte(CHAR_COMMA);
        send_byte("z");
        for (int i = 0; i < 4; i++)
            send_byte(CHAR_COMMA);
        send_text("y*");
    endtask

    // One sentence with random content; sometimes a broken header, raw bytes or no end.
    task automatic send_random_sentence();
        int         nfields;
        int         len;
        int         bad_at;
        logic [7:0] c;
        bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1;
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        for (int i = 0; i < 6; i++) begin
            c = (i == bad_at) ? 8'($urandom) : GGA_TAG[i];
            send_byte(c);
            sentence_words++;
        end
        nfields = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 12);
        for (int f = 0; f <= nfields; f++) begin
            if (f > 0) begin
                send_byte(CHAR_COMMA);
                sentence_words++;
            end
            if (f == 0)
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            else
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
            for (int k = 0; k < len; k++) begin
                c = 8'($urandom);
                // Now and then a raw comma or star slips into the data; a star cuts the sentence short.
                if ((c == CHAR_COMMA || c == CHAR_STAR) && $urandom_range(0, 3) != 0)
                    c = c ^ 8'h40;
                send_byte(c);
                sentence_words++;
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            send_byte(CHAR_STAR);
            sentence_words++;
        end
    endtask

    task automatic test_random_sentences();
        while (sentence_words < RANDOM_WORDS)
            send_random_sentence();
    endtask

    // The receiver holds off while a dense sentence keeps coming, so the input must stall.
    task automatic test_pressure();
        hold_left = HOLD_CYCLES;
        send_text("$GPGGA,");
        for (int i = 0; i < 48; i++) begin
            if (i % 12 == 11)
                send_byte(CHAR_COMMA);
            else
                send_byte(8'(8'h41 + $urandom_range(0, 25)));
        end
        send_byte(CHAR_STAR);
    endtask

    // Test sequence.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_hunting();
        test_field_extremes();
        test_field_limits();
        test_pressure();
        test_random_sentences();

        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gsfs_pkg.sv
hdl/gsfs_parser.sv
hdl/gga_sentence_field_splitter_top.sv
sim/tb_gga_sentence_field_splitter_top.sv
